/* rtl/core/pqe_pkg.sv */
// Package for the polyline quad expander: widths, register indexes, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pqe_pkg;
  localparam int IndexBitsDefault = 22;
  localparam int PosW = 22;
  localparam int FacW = 17;
  localparam int NrmW = 16;
  localparam int VidW = 22;
  localparam int AddrW = 4;

  localparam logic [AddrW-1:0] RegHalfScreen   = 4'd0;
  localparam logic [AddrW-1:0] RegLengthLimit  = 4'd4;
  localparam logic [AddrW-1:0] RegFactorCutoff = 4'd8;

  // Segment handed from the front to the back: the two raw points and the restart flag.
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic               restart;
  } seg_t;
endpackage
`default_nettype wire

/* rtl/core/pqe_front.sv */
// Front part: accepts points, keeps the previous point, forms segments.
// Depends on pqe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pqe_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [15:0]    in_point_x,
  input  wire logic [15:0]    in_point_y,
  input  wire logic           in_frame_start,
  output pqe_pkg::seg_t       seg_o,
  output logic                seg_valid_o,
  input  wire logic           seg_stall_i
);
  import pqe_pkg::*;
  logic [15:0] prev_x_r, prev_y_r;
  logic        have_prev_r;
  seg_t        seg_r;
  logic        seg_valid_r;
  logic        acc;

  // A restart marker is also a queue entry so vertex count clears in order.
  assign in_stall = seg_valid_r && seg_stall_i;
  assign acc = in_valid && !in_stall;
  assign seg_o = seg_r;
  assign seg_valid_o = seg_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      seg_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        prev_x_r    <= in_point_x;
        prev_y_r    <= in_point_y;
        have_prev_r <= 1'b1;
        seg_r.ax <= prev_x_r;
        seg_r.ay <= prev_y_r;
        seg_r.bx <= in_point_x;
        seg_r.by <= in_point_y;
        seg_r.restart <= in_frame_start;
        seg_valid_r <= in_frame_start || have_prev_r;
      end else if (seg_valid_r && !seg_stall_i) begin
        seg_valid_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/pqe_back.sv */
// Back part: scales, square root, divides, emits four vertices per segment that passes the cutoff and index limit.
// Depends on pqe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pqe_back #(
  parameter int INDEX_BITS = pqe_pkg::IndexBitsDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pqe_pkg::seg_t         seg_i,
  input  wire logic                  seg_valid_i,
  output logic                       seg_stall_o,
  input  wire logic [12:0]           half_screen,
  input  wire logic [15:0]           length_limit,
  input  wire logic [16:0]           factor_cutoff,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [21:0]                out_pos_x,
  output logic [21:0]                out_pos_y,
  output logic [16:0]                out_width_factor,
  output logic [15:0]                out_normal_x,
  output logic [15:0]                out_normal_y,
  output logic [21:0]                out_vertex_index,
  output logic                       out_last
);
  import pqe_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_SCALE = 4'd1, S_SQ = 4'd2, S_ROOT = 4'd3,
                         S_FDIV = 4'd4, S_NX = 4'd5, S_NY = 4'd6, S_DEC = 4'd7,
                         S_EMIT = 4'd8, S_SCALE2 = 4'd9;
  logic [3:0] state_r;
  seg_t seg_r;
  logic signed [21:0] ax_r, ay_r, bx_r, by_r;
  logic signed [22:0] dx_r, dy_r;
  logic [45:0] sq_r;
  // square root: 62-bit radicand, 31 result bits, one per cycle;
  // the partial root runs as wide as the radicand
  logic [63:0] rem_r;
  logic [63:0] root_r;
  logic [5:0]  cnt_r;
  // shared restoring divider, 48 quotient bits
  logic [63:0] num_r;
  logic [32:0] drem_r;
  logic [47:0] quo_r;
  logic [16:0] fac_r;
  logic signed [15:0] nx_r, ny_r;
  logic [INDEX_BITS:0] vcount_r;
  logic [1:0] k_r;
  logic out_valid_r;

  logic signed [28:0] prod_a, prod_b;
  logic signed [29:0] rnd_a, rnd_b;
  logic [63:0] rad;
  logic [63:0] trial;
  logic [33:0] dsub;
  logic [32:0] dshift;
  logic [47:0] qsat;
  logic [INDEX_BITS:0] vlimit;

  // Numerator is |d| << 23, placed so 48 quotient steps see it whole.
  function automatic logic [22:0] dmag_nx(input logic signed [22:0] d);
    dmag_nx = d[22] ? 23'(-d) : 23'(d);
  endfunction

  function automatic logic signed [15:0] sgn(input logic neg, input logic [47:0] q);
    logic [15:0] m;
    m = (q > 48'd32767) ? 16'd32767 : 16'(q);
    sgn = neg ? -$signed(m) : $signed(m);
  endfunction

  assign seg_stall_o = (state_r != S_IDLE);
  assign vlimit = {1'b1, {INDEX_BITS{1'b0}}};

  // Scale unit, used for start then end point.
  assign prod_a = $signed(state_r == S_SCALE ? seg_r.ax : seg_r.bx)
                  * $signed({1'b0, half_screen});
  assign prod_b = $signed(state_r == S_SCALE ? seg_r.ay : seg_r.by)
                  * $signed({1'b0, half_screen});
  assign rnd_a = (30'(prod_a) + 30'sd64) >>> 7;
  assign rnd_b = (30'(prod_b) + 30'sd64) >>> 7;

  assign rad = {2'b0, sq_r, 16'b0};
  assign trial = root_r + (64'd1 << {cnt_r, 1'b0});
  assign dshift = {drem_r[31:0], num_r[63]};
  assign dsub = {1'b0, dshift} - {2'b0, root_r[31:0]};
  assign qsat = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      k_r         <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (seg_valid_i) begin
            seg_r <= seg_i;
            if (seg_i.restart) vcount_r <= '0;
            else state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          ax_r <= 22'(rnd_a);
          ay_r <= 22'(rnd_b);
          state_r <= S_SCALE2;
        end
        S_SCALE2: begin
          bx_r <= 22'(rnd_a);
          by_r <= 22'(rnd_b);
          dx_r <= 23'(rnd_a) - 23'(ax_r);
          dy_r <= 23'(rnd_b) - 23'(ay_r);
          state_r <= S_SQ;
        end
        S_SQ: begin
          sq_r <= 46'(dx_r * dx_r) + 46'(dy_r * dy_r);
          state_r <= S_ROOT;
          cnt_r <= 6'd31;
          root_r <= '0;
          rem_r <= '0;
        end
        S_ROOT: begin
          // digit-by-digit root; rem_r holds the remaining radicand
          if (cnt_r == 6'd31) begin
            rem_r <= rad;
            cnt_r <= 6'd30;
          end else begin
            if (rem_r >= trial) begin
              rem_r  <= rem_r - trial;
              root_r <= (root_r >> 1) + (64'd1 << {cnt_r, 1'b0});
            end else begin
              root_r <= root_r >> 1;
            end
            if (cnt_r == 6'd0) begin
              state_r <= S_FDIV;
              num_r  <= {8'b0, length_limit, 40'b0};
              drem_r <= '0;
              quo_r  <= '0;
              cnt_r  <= 6'd48;
            end else cnt_r <= cnt_r - 6'd1;
          end
        end
        S_FDIV, S_NX, S_NY: begin
          if (root_r == '0) begin
            fac_r <= 17'd65536; nx_r <= '0; ny_r <= '0;
            state_r <= S_DEC;
          end else if (cnt_r != 6'd0) begin
            num_r <= num_r << 1;
            if (!dsub[33]) begin
              drem_r <= dsub[32:0];
              quo_r  <= {quo_r[46:0], 1'b1};
            end else begin
              drem_r <= dshift;
              quo_r  <= {quo_r[46:0], 1'b0};
            end
            cnt_r <= cnt_r - 6'd1;
          end else begin
            // 48 quotient bits of the top of a 64-bit numerator window
            drem_r <= '0;
            quo_r  <= '0;
            cnt_r  <= 6'd48;
            if (state_r == S_FDIV) begin
              fac_r <= (qsat > 48'd65536) ? 17'd65536 : 17'(qsat);
              num_r <= {2'b0, dmag_nx(dy_r), 39'b0};
              state_r <= S_NX;
            end else if (state_r == S_NX) begin
              nx_r <= sgn(dy_r[22], qsat);
              num_r <= {2'b0, dmag_nx(dx_r), 39'b0};
              state_r <= S_NY;
            end else begin
              ny_r <= sgn(~dx_r[22] && (dx_r != '0), qsat);
              state_r <= S_DEC;
            end
          end
        end
        S_DEC: begin
          if (fac_r > factor_cutoff && (vcount_r + (INDEX_BITS+1)'(4)) <= vlimit) begin
            k_r <= '0;
            out_valid_r <= 1'b1;
            state_r <= S_EMIT;
          end else state_r <= S_IDLE;
        end
        S_EMIT: begin
          if (!out_stall) begin
            k_r <= k_r + 2'd1;
            if (k_r == 2'd3) begin
              out_valid_r <= 1'b0;
              vcount_r <= vcount_r + (INDEX_BITS+1)'(4);
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Hold the vertex fields steady while valid.
  assign out_valid        = out_valid_r;
  assign out_pos_x        = k_r[1] ? bx_r : ax_r;
  assign out_pos_y        = k_r[1] ? by_r : ay_r;
  assign out_width_factor = fac_r;
  assign out_normal_x     = k_r[0] ? -nx_r : nx_r;
  assign out_normal_y     = k_r[0] ? -ny_r : ny_r;
  assign out_vertex_index = 22'(vcount_r + (INDEX_BITS+1)'(k_r));
  assign out_last         = (k_r == 2'd3);
endmodule
`default_nettype wire

/* rtl/core/polyline_to_quad_expander.sv */
// Top level of the polyline quad expander: register port, front, back.
// Depends on pqe_pkg, pqe_front, pqe_back.
// Path from point to first vertex: front register, scale, square root, three divides; no divides at zero length.
// The back part takes a new segment only once it has finished the last one; root and divider dominate, plus stalls.
// Reset: synchronous active-low; registers return to 512/2560/6554, no previous point.
`timescale 1ns / 1ps
`default_nettype none
module polyline_to_quad_expander #(
  parameter int INDEX_BITS = pqe_pkg::IndexBitsDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [15:0]                in_point_x,
  input  wire logic [15:0]                in_point_y,
  input  wire logic                       in_frame_start,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [21:0]                     out_pos_x,
  output logic [21:0]                     out_pos_y,
  output logic [16:0]                     out_width_factor,
  output logic [15:0]                     out_normal_x,
  output logic [15:0]                     out_normal_y,
  output logic [21:0]                     out_vertex_index,
  output logic                            out_last,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pqe_pkg::AddrW-1:0]  paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import pqe_pkg::*;
  logic [12:0] half_screen_r;
  logic [15:0] length_limit_r;
  logic [16:0] factor_cutoff_r;
  seg_t seg;
  logic seg_valid, seg_stall;

  assign pready = 1'b1;
  // Write registers on the access beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_screen_r   <= 13'd512;
      length_limit_r  <= 16'd2560;
      factor_cutoff_r <= 17'd6554;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        RegHalfScreen:   half_screen_r   <= pwdata[12:0];
        RegLengthLimit:  length_limit_r  <= pwdata[15:0];
        RegFactorCutoff: factor_cutoff_r <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegHalfScreen:   prdata = {19'b0, half_screen_r};
      RegLengthLimit:  prdata = {16'b0, length_limit_r};
      RegFactorCutoff: prdata = {15'b0, factor_cutoff_r};
      default:         prdata = '0;
    endcase
  end

  pqe_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_point_x, .in_point_y, .in_frame_start,
    .seg_o(seg), .seg_valid_o(seg_valid), .seg_stall_i(seg_stall)
  );

  pqe_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk, .rst_n, .seg_i(seg), .seg_valid_i(seg_valid), .seg_stall_o(seg_stall),
    .half_screen(half_screen_r), .length_limit(length_limit_r),
    .factor_cutoff(factor_cutoff_r),
    .out_valid, .out_stall, .out_pos_x, .out_pos_y, .out_width_factor,
    .out_normal_x, .out_normal_y, .out_vertex_index, .out_last
  );
endmodule
`default_nettype wire

/* rtl/core/pqe_checker.sv */
// Port-level checker for the polyline quad expander, bound to the top level.
// Depends on polyline_to_quad_expander ports only.
`timescale 1ns / 1ps
`default_nettype none
module pqe_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_last,
  input wire logic [21:0] out_vertex_index,
  input wire logic [16:0] out_width_factor
);
  // Index advances by one between beats of a quad.
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> !out_valid ||
      out_vertex_index == $past(out_vertex_index) + 22'd1)
    else $error("vertex index not consecutive");
  a_fac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_width_factor <= 17'd65536)
    else $error("factor above one");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vertex_index))
    else $error("stalled beat changed");
endmodule

bind polyline_to_quad_expander pqe_checker u_pqe_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_last, .out_vertex_index, .out_width_factor
);
`default_nettype wire

/* tb/tb.sv */
// Testbench for polyline_to_quad_expander: drives points and register writes,
// predicts the emitted quad vertices and checks every output beat. Depends on pqe_pkg.
`timescale 1ns / 1ps
module tb;
  import pqe_pkg::*;

  typedef struct packed {
    logic [21:0] pos_x;
    logic [21:0] pos_y;
    logic [16:0] factor;
    logic [15:0] nrm_x;
    logic [15:0] nrm_y;
    logic [21:0] vid;
    logic        last;
  } vertex_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_point_x;
  logic [15:0] in_point_y;
  logic        in_frame_start;
  logic        out_valid;
  logic        out_stall;
  logic [21:0] out_pos_x;
  logic [21:0] out_pos_y;
  logic [16:0] out_width_factor;
  logic [15:0] out_normal_x;
  logic [15:0] out_normal_y;
  logic [21:0] out_vertex_index;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  polyline_to_quad_expander u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_frame_start(in_frame_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_width_factor(out_width_factor),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_vertex_index(out_vertex_index), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow registers and strip state of the predictor
  longint unsigned shadow_half;
  longint unsigned shadow_limit;
  longint unsigned shadow_cutoff;
  logic [15:0]     last_px;
  logic [15:0]     last_py;
  bit              have_last;
  longint unsigned vcount;

  vertex_t vertex_q[$];
  int      errors;
  bit      send_gaps;
  bit      recv_gaps;
  logic [15:0] cur_x;
  logic [15:0] cur_y;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5ms;
    $display("tb NOT OK");
    $finish;
  end

  function automatic longint to_pixels(logic [15:0] raw);
    longint prod;
    prod = longint'($signed(raw)) * longint'(shadow_half);
    return (prod + 64) >>> 7;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_comp(longint d, longint unsigned len16);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = (mag << 23) / len16;
    if (q > 32767) q = 32767;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Expand one accepted point into its expected vertices
  task automatic expand_point(logic [15:0] px, logic [15:0] py, logic fs);
    longint ax, ay, bx, by, dx, dy, nx, ny, sx, sy;
    longint unsigned len16, factor;
    vertex_t v;
    if (!fs && have_last) begin
      ax = to_pixels(last_px);
      ay = to_pixels(last_py);
      bx = to_pixels(px);
      by = to_pixels(py);
      dx = bx - ax;
      dy = by - ay;
      len16 = int_sqrt(longint'(dx * dx + dy * dy) << 16);
      nx = 0;
      ny = 0;
      if (len16 == 0) begin
        factor = 65536;
      end else begin
        factor = (shadow_limit << 24) / len16;
        if (factor > 65536) factor = 65536;
        nx = unit_comp(dy, len16);
        ny = unit_comp(-dx, len16);
      end
      if (factor > shadow_cutoff && vcount + 4 <= (64'd1 << IndexBitsDefault)) begin
        for (int k = 0; k < 4; k++) begin
          sx = (k & 1) ? -nx : nx;
          sy = (k & 1) ? -ny : ny;
          v.pos_x  = (k < 2) ? ax[21:0] : bx[21:0];
          v.pos_y  = (k < 2) ? ay[21:0] : by[21:0];
          v.factor = factor[16:0];
          v.nrm_x  = sx[15:0];
          v.nrm_y  = sy[15:0];
          v.vid    = 22'(vcount + k);
          v.last   = (k == 3);
          vertex_q = {vertex_q, v};
        end
        vcount += 4;
      end
    end
    if (fs) vcount = 0;
    last_px = px;
    last_py = py;
    have_last = 1'b1;
  endtask

  // Send one point beat; called and returns at a falling edge
  task automatic send_point(logic [15:0] px, logic [15:0] py, logic fs);
    int gap;
    gap = send_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_point_x     <= px;
    in_point_y     <= py;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    expand_point(px, py, fs);
    cur_x = px;
    cur_y = py;
    @(negedge clk);
  endtask

  // Hold off until every expected vertex is out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  task automatic write_reg(logic [AddrW-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      RegHalfScreen:   shadow_half   = data & 32'h1FFF;
      RegLengthLimit:  shadow_limit  = data & 32'hFFFF;
      RegFactorCutoff: shadow_cutoff = data & 32'h1FFFF;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] hs, logic [31:0] ll, logic [31:0] fc);
    drain();
    write_reg(RegHalfScreen, hs);
    write_reg(RegLengthLimit, ll);
    write_reg(RegFactorCutoff, fc);
  endtask

  // Result side stall: random wait per beat, with some stretches at full rate
  initial begin
    int w;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      w = recv_gaps ? $urandom_range(0, 7) : 0;
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each vertex beat with the oldest expectation
  always @(posedge clk) begin
    vertex_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) begin
        $display("%0t unexpected vertex idx=%0d", $time, out_vertex_index);
        errors++;
      end else begin
        exp_v = vertex_q.pop_front();
        if (exp_v.pos_x !== out_pos_x) begin
          $display("%0t pos_x exp %h got %h", $time, exp_v.pos_x, out_pos_x);
          errors++;
        end
        if (exp_v.pos_y !== out_pos_y) begin
          $display("%0t pos_y exp %h got %h", $time, exp_v.pos_y, out_pos_y);
          errors++;
        end
        if (exp_v.factor !== out_width_factor) begin
          $display("%0t width_factor exp %h got %h", $time, exp_v.factor, out_width_factor);
          errors++;
        end
        if (exp_v.nrm_x !== out_normal_x) begin
          $display("%0t normal_x exp %h got %h", $time, exp_v.nrm_x, out_normal_x);
          errors++;
        end
        if (exp_v.nrm_y !== out_normal_y) begin
          $display("%0t normal_y exp %h got %h", $time, exp_v.nrm_y, out_normal_y);
          errors++;
        end
        if (exp_v.vid !== out_vertex_index) begin
          $display("%0t vertex_index exp %h got %h", $time, exp_v.vid, out_vertex_index);
          errors++;
        end
        if (exp_v.last !== out_last) begin
          $display("%0t last exp %b got %b", $time, exp_v.last, out_last);
          errors++;
        end
      end
    end
  end

  // Default registers: first point only stored, short segments, zero length
  task automatic test_defaults();
    send_point(16'd100, 16'd200, 1'b0);
    send_point(16'd110, 16'd205, 1'b0);
    send_point(16'd110, 16'd205, 1'b0);
    send_point(16'hFFF0, 16'd210, 1'b0);
    send_point(16'd0, 16'd0, 1'b1);
    send_point(16'd3, 16'hFFFE, 1'b0);
    send_point(16'h7FFF, 16'h8000, 1'b0);
    send_point(16'h7FF8, 16'h8005, 1'b0);
  endtask

  // Register extremes with field extremes
  task automatic test_extremes();
    set_regs(32'd4096, 32'd65535, 32'd0);
    send_point(16'h8000, 16'h8000, 1'b1);
    send_point(16'h7FFF, 16'h7FFF, 1'b0);
    send_point(16'h8000, 16'h7FFF, 1'b0);
    send_point(16'h8000, 16'h7FFF, 1'b0);
    send_point(16'h8001, 16'h7FFE, 1'b0);
    set_regs(32'd1, 32'd0, 32'd65536);
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd64, 16'hFFC0, 1'b0);
    set_regs(32'd1, 32'd65535, 32'd0);
    send_point(16'd63, 16'd65, 1'b0);
    send_point(16'hFFC1, 16'd200, 1'b0);
    send_point(16'h7FFF, 16'h8000, 1'b0);
    set_regs(32'd0, 32'd1000, 32'd0);
    send_point(16'h1234, 16'h5678, 1'b0);
    send_point(16'hFEDC, 16'h8765, 1'b0);
  endtask

  // Random strips under several register settings
  task automatic test_random(int count);
    logic [15:0] nx, ny;
    logic        fs;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: set_regs(32'd512, 32'd2560, 32'd6554);
          1: set_regs(32'd4096, 32'd65535, $urandom_range(0, 65536));
          2: set_regs($urandom_range(1, 4096), $urandom, $urandom_range(0, 20000));
          default: set_regs($urandom_range(1, 64), $urandom_range(0, 65535), 32'd0);
        endcase
        send_gaps = $urandom_range(0, 3) != 0;
        recv_gaps = $urandom_range(0, 3) != 0;
      end
      fs = ($urandom_range(0, 15) == 0);
      if ($urandom_range(0, 9) == 0) begin
        nx = $urandom;
        ny = $urandom;
      end else begin
        nx = cur_x + 16'($signed($urandom_range(0, 80)) - 40);
        ny = cur_y + 16'($signed($urandom_range(0, 80)) - 40);
      end
      send_point(nx, ny, fs);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_frame_start = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    shadow_half = 512;
    shadow_limit = 2560;
    shadow_cutoff = 6554;
    last_px = '0;
    last_py = '0;
    have_last = 1'b0;
    vcount = 0;
    cur_x = '0;
    cur_y = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_defaults();
    test_extremes();
    test_random(110);
    drain();
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

/* polyline_to_quad_expander.f */
rtl/core/pqe_pkg.sv
rtl/core/pqe_front.sv
rtl/core/pqe_back.sv
rtl/core/polyline_to_quad_expander.sv
rtl/core/pqe_checker.sv
tb/tb.sv
